// ===== design/smcp_pkg.sv =====
`timescale 1ns / 1ps

package smcp_pkg;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned DEPTH_W = 10;
	localparam int unsigned BND_W   = 11;
	localparam int unsigned OFF_W   = 10;
	localparam int unsigned SUM_W   = 18;
	localparam int unsigned CNT_W   = 11;
	localparam int unsigned MEAN_W  = 8;

	// window end: lower boundary (10 bit) plus offset (10 bit)
	localparam int unsigned END_W   = 12;

	localparam logic [OFF_W-1:0]   OFFSET_RESET = 10'd150;
	localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0]   CNT_MAX      = {CNT_W{1'b1}};
	localparam logic [MEAN_W-1:0]  MEAN_MAX     = {MEAN_W{1'b1}};

	// column size; a depth at or past it is never counted
	localparam logic [END_W:0]     MAX_DEPTH    = 13'd1024;

	// restoring divider, one quotient bit per cycle
	localparam int unsigned DIV_STEPS = SUM_W;
	localparam int unsigned STEP_W    = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	typedef struct packed {
		logic [SUM_W-1:0] gray_sum;
		logic [CNT_W-1:0] count;
	} col_acc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_HOLD
	} bk_state_t;

endpackage

// ===== design/smcp_front.sv =====
`timescale 1ns / 1ps

module smcp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [smcp_pkg::PIX_W-1:0]  pixel,
	input  logic [smcp_pkg::DEPTH_W-1:0] depth,
	input  logic signed [smcp_pkg::BND_W-1:0] upper_y,
	input  logic signed [smcp_pkg::BND_W-1:0] lower_y,
	input  logic                        last_in_column,
	input  logic [smcp_pkg::OFF_W-1:0]  bottom_offset,
	input  smcp_pkg::q_status_t         q_status,
	output logic                        push,
	output smcp_pkg::col_acc_t          push_data
);
	import smcp_pkg::*;

	logic [SUM_W-1:0]   gray_sum_q;
	logic [CNT_W-1:0]   in_window_count_q;
	logic [DEPTH_W-1:0] start_row;
	logic [END_W-1:0]   end_row;
	logic               below_start;
	logic               past_end;
	logic               past_column;
	logic               in_window;
	logic [SUM_W:0]     sum_wide;
	logic [SUM_W-1:0]   sum_next;
	logic [CNT_W-1:0]   cnt_next;
	logic               accept;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	// missing upper boundary opens the window at row 0
	assign start_row   = upper_y[BND_W-1] ? '0 : upper_y[DEPTH_W-1:0];
	assign end_row     = END_W'(lower_y[DEPTH_W-1:0]) + END_W'(bottom_offset);
	assign below_start = depth < start_row;
	assign past_end    = !lower_y[BND_W-1] && (END_W'(depth) > end_row);
	assign past_column = ({(END_W+1-DEPTH_W)'(0), depth} >= MAX_DEPTH);
	assign in_window   = !below_start && !past_end && !past_column;

	assign sum_wide = {1'b0, gray_sum_q} + (SUM_W+1)'(pixel);

	always_comb begin
		sum_next = gray_sum_q;
		cnt_next = in_window_count_q;
		if (in_window) begin
			sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
			if (in_window_count_q != CNT_MAX) begin
				cnt_next = in_window_count_q + CNT_W'(1);
			end
		end
	end

	assign push               = accept && last_in_column;
	assign push_data.gray_sum = sum_next;
	assign push_data.count    = cnt_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_sum_q        <= '0;
			in_window_count_q <= '0;
		end else if (accept) begin
			if (last_in_column) begin
				gray_sum_q        <= '0;
				in_window_count_q <= '0;
			end else begin
				gray_sum_q        <= sum_next;
				in_window_count_q <= cnt_next;
			end
		end
	end

endmodule

// ===== design/smcp_queue.sv =====
`timescale 1ns / 1ps

module smcp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  smcp_pkg::col_acc_t  push_data,
	input  logic                pop,
	output smcp_pkg::col_acc_t  pop_data,
	output smcp_pkg::q_status_t status
);
	import smcp_pkg::*;

	col_acc_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign status.full  = (fill_q == 2'd2);
	assign status.empty = (fill_q == 2'd0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ===== design/smcp_back.sv =====
`timescale 1ns / 1ps

module smcp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  smcp_pkg::q_status_t         q_status,
	input  smcp_pkg::col_acc_t          pop_data,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [smcp_pkg::MEAN_W-1:0] mean_gray,
	output logic [smcp_pkg::CNT_W-1:0]  sample_count
);
	import smcp_pkg::*;

	bk_state_t        state_q;
	bk_state_t        state_next;
	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] div_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]   shifted;
	logic             fits;
	logic [CNT_W:0]   diff;

	// one restoring step
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign fits    = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					state_next = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == LAST_STEP) begin
					state_next = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (!out_stall) begin
					state_next = BK_IDLE;
				end
			end
			default: state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			BK_IDLE: pop       = !q_status.empty;
			BK_HOLD: out_valid = 1'b1;
			default: begin
				pop       = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == BK_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q <= '0;
			quo_q <= pop_data.gray_sum;
			div_q <= pop_data.count;
		end else if (state_q == BK_DIV) begin
			rem_q <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	// empty window gives zero; quotient past 8 bits clamps
	always_comb begin
		if (div_q == '0) begin
			mean_gray = '0;
		end else if (|quo_q[SUM_W-1:MEAN_W]) begin
			mean_gray = MEAN_MAX;
		end else begin
			mean_gray = quo_q[MEAN_W-1:0];
		end
	end

	assign sample_count = div_q;

endmodule

// ===== design/slab_mean_column_projection.sv =====
`timescale 1ns / 1ps

// Slab mean projection of one image column.
// Input channel (in_valid / in_stall): one pixel per transfer with its depth,
// the column's upper and lower boundary rows (negative = missing) and
// last_in_column on the final pixel. Pixels inside the window from the upper
// boundary through lower boundary + bottom_offset are summed and counted.
// Output channel (out_valid / out_stall): one transfer per column carrying the
// truncated mean (0 for an empty window) and the in-window pixel count.
// Throughput: one pixel per cycle while in_stall is low. Each column result
// goes through an 18-step restoring divider; after the column's last pixel,
// its queue entry loads the divider, which runs its 18 divide steps and then
// raises out_valid; it holds the result until transferred and only then takes
// the next column. The two-entry queue between the accumulator and the
// divider absorbs column ends; columns that end faster than the divider
// finishes them fill it, then in_stall rises until the divider frees an entry.
// A stalled result holds on the outputs and keeps the divider busy; pixels
// keep flowing until the queue is full. The user must write bottom_offset
// through cfg_we / cfg_wdata only while idle; the block leaves this to the user.
// Reset (arst_n low) clears the accumulators, empties the queue, idles the
// divider and sets bottom_offset to 150.
module slab_mean_column_projection (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [smcp_pkg::OFF_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [smcp_pkg::PIX_W-1:0]         pixel,
	input  logic [smcp_pkg::DEPTH_W-1:0]       depth,
	input  logic signed [smcp_pkg::BND_W-1:0]  upper_y,
	input  logic signed [smcp_pkg::BND_W-1:0]  lower_y,
	input  logic                               last_in_column,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [smcp_pkg::MEAN_W-1:0]        mean_gray,
	output logic [smcp_pkg::CNT_W-1:0]         sample_count
);
	import smcp_pkg::*;

	logic [OFF_W-1:0] bottom_offset_q;
	q_status_t        q_status;
	logic             push;
	col_acc_t         push_data;
	logic             pop;
	col_acc_t         pop_data;

	// window offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			bottom_offset_q <= cfg_wdata;
		end
	end

	// front: window test and per-column accumulation
	smcp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel          (pixel),
		.depth          (depth),
		.upper_y        (upper_y),
		.lower_y        (lower_y),
		.last_in_column (last_in_column),
		.bottom_offset  (bottom_offset_q),
		.q_status       (q_status),
		.push           (push),
		.push_data      (push_data)
	);

	// finished column totals wait here for the divider
	smcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// back: mean by serial division, result held until transferred
	smcp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_gray    (mean_gray),
		.sample_count (sample_count)
	);

endmodule
